>>> rtl/key_payload_insertion_sorter_core_macros.svh
// Assertion macros for the key/payload insertion sorter.
`ifndef KEY_PAYLOAD_INSERTION_SORTER_CORE_MACROS_SVH
`define KEY_PAYLOAD_INSERTION_SORTER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define KPIS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("kpis: property violated");
`define KPIS_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("kpis: forbidden condition");
`else
`define KPIS_ASSERT(lbl, clk, rstn, prop)
`define KPIS_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

>>> rtl/kpis_pkg.sv
package kpis_pkg;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned TAG_W = 32;
  localparam int unsigned REC_W = KEY_W + TAG_W;

  typedef enum logic [1:0] {
    RD_COUNT = 2'd0,
    RD_POS   = 2'd1,
    RD_EMIT  = 2'd2
  } rd_src_e;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_CMP      = 6'b000010,
    ST_PLACE    = 6'b000100,
    ST_EMIT_RD  = 6'b001000,
    ST_EMIT_LD  = 6'b010000,
    ST_EMIT_OUT = 6'b100000
  } state_e;

  typedef struct packed {
    logic    load;
    logic    set_drop;
    logic    shift;
    logic    place;
    logic    emit_start;
    logic    emit_load;
    logic    clear;
    rd_src_e rd_src;
  } kpis_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_one;
    logic key_gt;
    logic last;
    logic run_last;
  } kpis_sts_t;

endpackage

>>> rtl/kpis_ctrl.sv
module kpis_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  kpis_pkg::kpis_sts_t sts_i,
  output kpis_pkg::kpis_cmd_t cmd_o
);
  import kpis_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT_OUT);

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.rd_src = RD_EMIT;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.full) begin
            // store full: record dropped
            cmd_o.set_drop = 1'b1;
            if (in_last_i) begin
              cmd_o.emit_start = 1'b1;
              state_d          = ST_EMIT_RD;
            end
          end else if (sts_i.empty) begin
            state_d = ST_PLACE;
          end else begin
            cmd_o.rd_src = RD_COUNT;
            state_d      = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (sts_i.key_gt) begin
          cmd_o.shift = 1'b1;
          if (sts_i.pos_one) begin
            state_d = ST_PLACE;
          end else begin
            cmd_o.rd_src = RD_POS;
          end
        end else begin
          cmd_o.place      = 1'b1;
          cmd_o.emit_start = sts_i.last;
          state_d          = sts_i.last ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_PLACE: begin
        cmd_o.place      = 1'b1;
        cmd_o.emit_start = sts_i.last;
        state_d          = sts_i.last ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd_o.emit_load = 1'b1;
        state_d         = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_ready_i) begin
          if (sts_i.run_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_EMIT_LD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/kpis_dp.sv
`include "key_payload_insertion_sorter_core_macros.svh"

module kpis_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [kpis_pkg::KEY_W-1:0] in_key_i,
  input  logic [kpis_pkg::TAG_W-1:0] in_tag_i,
  input  logic                      in_last_i,
  input  kpis_pkg::kpis_cmd_t       cmd_i,
  output kpis_pkg::kpis_sts_t       sts_o,
  output logic [kpis_pkg::KEY_W-1:0] out_key_o,
  output logic [kpis_pkg::TAG_W-1:0] out_tag_o,
  output logic                      out_last_o,
  output logic                      out_ovf_o
);
  import kpis_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [REC_W-1:0] store_q [DEPTH];
  logic [REC_W-1:0] rd_data_q;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [REC_W-1:0] wr_data;

  logic [CW-1:0]    count_q;
  logic             drop_q;
  logic [AW-1:0]    pos_q;
  logic [AW-1:0]    idx_q;
  logic             last_q;
  logic [KEY_W-1:0] key_q;
  logic [TAG_W-1:0] tag_q;
  logic [KEY_W-1:0] out_key_q;
  logic [TAG_W-1:0] out_tag_q;
  logic             out_last_q;
  logic             out_ovf_q;

  always_comb begin
    unique case (cmd_i.rd_src)
      RD_COUNT: rd_addr = AW'(count_q - CW'(1));
      RD_POS:   rd_addr = pos_q - AW'(2);
      RD_EMIT:  rd_addr = idx_q;
      default:  rd_addr = idx_q;
    endcase
  end

  assign wr_en   = cmd_i.shift | cmd_i.place;
  assign wr_data = cmd_i.shift ? rd_data_q : {tag_q, key_q};

  // record store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[pos_q] <= wr_data;
    end
    rd_data_q <= store_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
      pos_q   <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.place) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.clear) begin
        drop_q <= 1'b0;
      end else if (cmd_i.set_drop) begin
        drop_q <= 1'b1;
      end
      if (cmd_i.load) begin
        pos_q  <= count_q[AW-1:0];
        last_q <= in_last_i;
      end else if (cmd_i.shift) begin
        pos_q <= pos_q - AW'(1);
      end
      if (cmd_i.emit_start) begin
        idx_q <= '0;
      end else if (cmd_i.emit_load) begin
        idx_q <= idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= in_key_i;
      tag_q <= in_tag_i;
    end
    if (cmd_i.emit_load) begin
      out_key_q  <= rd_data_q[KEY_W-1:0];
      out_tag_q  <= rd_data_q[REC_W-1:KEY_W];
      out_last_q <= (CW'(idx_q) + CW'(1)) == count_q;
      out_ovf_q  <= drop_q;
    end
  end

  assign sts_o.full     = (count_q == CW'(DEPTH));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.pos_one  = (pos_q == AW'(1));
  assign sts_o.key_gt   = rd_data_q[KEY_W-1:0] > key_q;
  assign sts_o.last     = last_q;
  assign sts_o.run_last = out_last_q;

  assign out_key_o  = out_key_q;
  assign out_tag_o  = out_tag_q;
  assign out_last_o = out_last_q;
  assign out_ovf_o  = out_ovf_q;

  `KPIS_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CW'(DEPTH))
  `KPIS_ASSERT(a_shift_pos, clk_i, rst_ni, cmd_i.shift |-> pos_q != '0)
  `KPIS_ASSERT(a_emit_idx, clk_i, rst_ni, cmd_i.emit_load |-> CW'(idx_q) < count_q)

endmodule

>>> rtl/key_payload_insertion_sorter_core.sv
// Stable insertion sorter for key/tag records.
// Input stream: each transfer carries one record (tdata = key, tag); tlast marks the
// record that closes the set. Records are inserted in ascending key order as they
// arrive; equal keys keep arrival order. Up to DEPTH records are held, further ones
// are dropped and the run is flagged on tuser.
// Insertion walks the store one entry per cycle from the top down, and the next record
// is taken only once the current one is placed or dropped. The single write port of
// the store bounds this.
// After the closing record the sorted run is sent on the output stream, tlast on the
// final record. tvalid rises once the controller has passed its EMIT_RD and EMIT_LD
// states after the closing record is placed or dropped; each further result is loaded
// in EMIT_LD once the previous one is taken. No input is taken while a run is being sent.
// A stalled result holds tdata/tlast/tuser stable until taken. Reset empties the set
// and clears the drop flag; store contents are not cleared and need no sweep.
module key_payload_insertion_sorter_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // sort_key[15:0], payload_tag[47:16]
  input  logic        s_axis_tlast_i,  // set_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // out_key[15:0], out_tag[47:16]
  output logic        m_axis_tlast_o,  // out_last
  output logic        m_axis_tuser_o   // overflowed
);
  import kpis_pkg::*;

  kpis_cmd_t        cmd;
  kpis_sts_t        sts;
  logic [KEY_W-1:0] out_key;
  logic [TAG_W-1:0] out_tag;

  kpis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kpis_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_key_i   (s_axis_tdata_i[KEY_W-1:0]),
    .in_tag_i   (s_axis_tdata_i[REC_W-1:KEY_W]),
    .in_last_i  (s_axis_tlast_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_key_o  (out_key),
    .out_tag_o  (out_tag),
    .out_last_o (m_axis_tlast_o),
    .out_ovf_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {out_tag, out_key};

endmodule
